FILE: sv/http_header_byte_parser_defines.svh
// assertion macros for the http header byte parser
`ifndef HTTP_HEADER_BYTE_PARSER_DEFINES_SVH
`define HTTP_HEADER_BYTE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, held off during reset
`define HBP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, held off during reset
`define HBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HBP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define HBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: sv/hbp_pkg.sv
// shared types and codes for the http header byte parser
`timescale 1ns / 1ps
`default_nettype none

package hbp_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned NameW   = 8;
  localparam int unsigned ValueW  = 12;
  localparam int unsigned StateW  = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned RoleW   = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 12;

  // limit register reset values
  localparam logic [NameW-1:0]  NAME_LIMIT_RST  = 8'd64;
  localparam logic [ValueW-1:0] VALUE_LIMIT_RST = 12'd1024;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_NAME_LIMIT  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_VALUE_LIMIT = 1'd1;

  // parser states
  localparam logic [StateW-1:0] ST_LINE_START = 3'd0;
  localparam logic [StateW-1:0] ST_FOLD_WS    = 3'd1;
  localparam logic [StateW-1:0] ST_NAME       = 3'd2;
  localparam logic [StateW-1:0] ST_SPACE      = 3'd3;
  localparam logic [StateW-1:0] ST_VAL_START  = 3'd4;
  localparam logic [StateW-1:0] ST_VALUE      = 3'd5;
  localparam logic [StateW-1:0] ST_NL_LINE    = 3'd6;
  localparam logic [StateW-1:0] ST_NL_END     = 3'd7;

  // status codes
  localparam logic [StatusW-1:0] STAT_MORE  = 2'd0;
  localparam logic [StatusW-1:0] STAT_OK    = 2'd1;
  localparam logic [StatusW-1:0] STAT_ERROR = 2'd2;

  // role tags
  localparam logic [RoleW-1:0] ROLE_NONE      = 3'd0;
  localparam logic [RoleW-1:0] ROLE_NEW_NAME  = 3'd1;
  localparam logic [RoleW-1:0] ROLE_NAME_ADD  = 3'd2;
  localparam logic [RoleW-1:0] ROLE_NEW_VALUE = 3'd3;
  localparam logic [RoleW-1:0] ROLE_VALUE_ADD = 3'd4;
  localparam logic [RoleW-1:0] ROLE_COMPLETE  = 3'd5;

  // character constants
  localparam logic [ByteW-1:0] CH_CR    = 8'h0d;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0a;
  localparam logic [ByteW-1:0] CH_COLON = 8'h3a;
  localparam logic [ByteW-1:0] CH_TAB   = 8'h09;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_DEL   = 8'h7f;

  // parser context carried between words
  typedef struct packed {
    logic [StateW-1:0] state;
    logic [NameW-1:0]  name_len;
    logic [ValueW-1:0] value_len;
  } ctx_t;

  // length limits
  typedef struct packed {
    logic [NameW-1:0]  name_limit;
    logic [ValueW-1:0] value_limit;
  } limits_t;

  // outcome of one byte
  typedef struct packed {
    ctx_t               ctx;
    logic [StatusW-1:0] status;
    logic [RoleW-1:0]   role;
  } step_t;

endpackage

`default_nettype wire

FILE: sv/hbp_step.sv
// header grammar: next context, status and role for one byte
`timescale 1ns / 1ps
`default_nettype none

module hbp_step (
  input  wire logic [hbp_pkg::ByteW-1:0] data_byte,
  input  wire logic                      restart,
  input  wire hbp_pkg::ctx_t             ctx,
  input  wire hbp_pkg::limits_t          limits,
  output hbp_pkg::step_t                 step
);

  logic is_ascii;
  logic is_ctl;
  logic is_ws;
  logic name_room;
  logic value_room;

  // character classes and limit checks
  assign is_ascii   = ~data_byte[7];
  assign is_ctl     = (data_byte[7:5] == 3'd0) || (data_byte == hbp_pkg::CH_DEL);
  assign is_ws      = (data_byte == hbp_pkg::CH_SPACE) || (data_byte == hbp_pkg::CH_TAB);
  assign name_room  = ctx.name_len < limits.name_limit;
  assign value_room = ctx.value_len < limits.value_limit;

  // grammar; an error keeps the context as it is
  always_comb begin
    step.ctx    = ctx;
    step.status = hbp_pkg::STAT_ERROR;
    step.role   = hbp_pkg::ROLE_NONE;
    if (restart) begin
      step.ctx.state     = hbp_pkg::ST_LINE_START;
      step.ctx.name_len  = '0;
      step.ctx.value_len = '0;
      step.status        = hbp_pkg::STAT_MORE;
    end else begin
      unique case (ctx.state)
        hbp_pkg::ST_LINE_START: begin
          if (data_byte == hbp_pkg::CH_CR) begin
            step.ctx.state = hbp_pkg::ST_NL_END;
            step.status    = hbp_pkg::STAT_MORE;
          end else if (is_ws) begin
            // fold only after a header has been seen
            if (ctx.name_len != '0) begin
              step.ctx.state = hbp_pkg::ST_FOLD_WS;
              step.status    = hbp_pkg::STAT_MORE;
            end
          end else if (is_ascii) begin
            step.ctx.name_len = hbp_pkg::NameW'(1);
            step.ctx.state    = hbp_pkg::ST_NAME;
            step.status       = hbp_pkg::STAT_MORE;
            step.role         = hbp_pkg::ROLE_NEW_NAME;
          end
        end
        hbp_pkg::ST_FOLD_WS: begin
          if (data_byte == hbp_pkg::CH_CR) begin
            step.ctx.state = hbp_pkg::ST_NL_LINE;
            step.status    = hbp_pkg::STAT_MORE;
          end else if (is_ws) begin
            step.status = hbp_pkg::STAT_MORE;
          end else if (!is_ctl && value_room) begin
            step.ctx.value_len = ctx.value_len + hbp_pkg::ValueW'(1);
            step.ctx.state     = hbp_pkg::ST_VALUE;
            step.status        = hbp_pkg::STAT_MORE;
            step.role          = hbp_pkg::ROLE_VALUE_ADD;
          end
        end
        hbp_pkg::ST_NAME: begin
          if (data_byte == hbp_pkg::CH_COLON) begin
            step.ctx.state = hbp_pkg::ST_SPACE;
            step.status    = hbp_pkg::STAT_MORE;
          end else if (is_ascii && name_room) begin
            step.ctx.name_len = ctx.name_len + hbp_pkg::NameW'(1);
            step.status       = hbp_pkg::STAT_MORE;
            step.role         = hbp_pkg::ROLE_NAME_ADD;
          end
        end
        hbp_pkg::ST_SPACE: begin
          if (data_byte == hbp_pkg::CH_SPACE) begin
            step.ctx.state = hbp_pkg::ST_VAL_START;
            step.status    = hbp_pkg::STAT_MORE;
          end
        end
        hbp_pkg::ST_VAL_START: begin
          if (!is_ctl) begin
            step.ctx.value_len = hbp_pkg::ValueW'(1);
            step.ctx.state     = hbp_pkg::ST_VALUE;
            step.status        = hbp_pkg::STAT_MORE;
            step.role          = hbp_pkg::ROLE_NEW_VALUE;
          end
        end
        hbp_pkg::ST_VALUE: begin
          if (data_byte == hbp_pkg::CH_CR) begin
            step.ctx.state = hbp_pkg::ST_NL_LINE;
            step.status    = hbp_pkg::STAT_MORE;
            step.role      = hbp_pkg::ROLE_COMPLETE;
          end else if (!is_ctl && value_room) begin
            step.ctx.value_len = ctx.value_len + hbp_pkg::ValueW'(1);
            step.status        = hbp_pkg::STAT_MORE;
            step.role          = hbp_pkg::ROLE_VALUE_ADD;
          end
        end
        hbp_pkg::ST_NL_LINE: begin
          if (data_byte == hbp_pkg::CH_LF) begin
            step.ctx.state = hbp_pkg::ST_LINE_START;
            step.status    = hbp_pkg::STAT_MORE;
          end
        end
        default: begin
          // blank line seen: every further lf is ok again
          if (data_byte == hbp_pkg::CH_LF) begin
            step.status = hbp_pkg::STAT_OK;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/http_header_byte_parser.sv
// Top level of the http header byte parser.
// Path: an accepted byte goes through the input register, then the grammar logic, and its
// result is held in the result register until out_ready takes it.
// Throughput: one byte per cycle unless out_ready low holds the result register; the context registers close a loop.
// Reset (rst_n low, synchronous): both stages empty, line start, lengths zero,
// name limit 64 and value limit 1024.
`timescale 1ns / 1ps
`default_nettype none

`include "http_header_byte_parser_defines.svh"

module http_header_byte_parser (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input words
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [hbp_pkg::ByteW-1:0]     in_data_byte,
  input  wire logic                          in_restart,
  // result words
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [hbp_pkg::StatusW-1:0]   out_status,
  output      logic [hbp_pkg::RoleW-1:0]     out_role,
  output      logic [hbp_pkg::ByteW-1:0]     out_echo_byte,
  // configuration writes
  input  wire logic                          cfg_we,
  input  wire logic [hbp_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [hbp_pkg::CfgDatW-1:0]   cfg_wdata
);

  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic [hbp_pkg::ByteW-1:0]     s1_byte_r;
  logic                          s1_restart_r;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [hbp_pkg::StatusW-1:0]   out_status_r;
  logic [hbp_pkg::RoleW-1:0]     out_role_r;
  logic [hbp_pkg::ByteW-1:0]     out_echo_r;
  hbp_pkg::ctx_t                 ctx_r;
  hbp_pkg::limits_t              limits_r;
  hbp_pkg::step_t                step;
  logic                          advance;
  logic                          in_fire;

  // handshake between the two stages
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  // grammar logic between input and result registers
  hbp_step u_step (
    .data_byte (s1_byte_r),
    .restart   (s1_restart_r),
    .ctx       (ctx_r),
    .limits    (limits_r),
    .step      (step)
  );

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r    <= in_data_byte;
      s1_restart_r <= in_restart;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= step.status;
      out_role_r   <= step.role;
      out_echo_r   <= s1_restart_r ? '0 : s1_byte_r;
    end
  end

  // parser context
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.state     <= hbp_pkg::ST_LINE_START;
      ctx_r.name_len  <= '0;
      ctx_r.value_len <= '0;
    end else if (advance) begin
      ctx_r <= step.ctx;
    end
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.name_limit  <= hbp_pkg::NAME_LIMIT_RST;
      limits_r.value_limit <= hbp_pkg::VALUE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbp_pkg::REG_NAME_LIMIT:  limits_r.name_limit  <= cfg_wdata[hbp_pkg::NameW-1:0];
        hbp_pkg::REG_VALUE_LIMIT: limits_r.value_limit <= cfg_wdata[hbp_pkg::ValueW-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_role      = out_role_r;
  assign out_echo_byte = out_echo_r;

  // checks
  `HBP_ASSERT_IMPL(a_err_no_role, clk, rst_n,
    out_valid && (out_status == hbp_pkg::STAT_ERROR), out_role == hbp_pkg::ROLE_NONE,
    "error word carries a role")
  `HBP_ASSERT_IMPL(a_ok_no_role, clk, rst_n,
    out_valid && (out_status == hbp_pkg::STAT_OK), out_role == hbp_pkg::ROLE_NONE,
    "ok word carries a role")
  `HBP_ASSERT_IMPL(a_name_len, clk, rst_n,
    ctx_r.state == hbp_pkg::ST_NAME, ctx_r.name_len != '0,
    "in name with zero name length")
  `HBP_ASSERT_IMPL(a_value_len, clk, rst_n,
    ctx_r.state == hbp_pkg::ST_VALUE, ctx_r.value_len != '0,
    "in value with zero value length")
  `HBP_ASSERT_NEXT(a_ctx_hold, clk, rst_n, !advance, $stable(ctx_r),
    "context moved without a word")

endmodule

`default_nettype wire
